// ----- sv/arcpg_pkg.sv -----
// Shared types and constants for the arc point generator.
// Depends on nothing; imported by arc_point_generator_unit.
package arcpg_pkg;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_CENTER_X    = 3'd0,
        REG_CENTER_Y    = 3'd1,
        REG_RADIUS      = 3'd2,
        REG_START_ANGLE = 3'd3,
        REG_END_ANGLE   = 3'd4,
        REG_POINT_COUNT = 3'd5
    } cfg_reg_t;

    localparam int MinPoints   = 3;
    localparam int FullTurn    = 23592960;   // 360 degrees in 1/65536 degree
    localparam int QuarterTurn = FullTurn / 4;
    localparam int HalfTurn    = FullTurn / 2;
    localparam int ThreeQuarter = 3 * (FullTurn / 4);
    localparam int CordicGain  = 652032874;  // 0.6072529350 in Q30

    // Width of the angle quotient magnitude, and of the shifted angle.
    localparam int QuoW   = 27;
    localparam int AngW   = 28;
    localparam int WrapW  = 29;
    localparam int CorW   = 34;

    // Status that rides along with each request.
    typedef struct packed {
        logic index_valid;
        logic is_last_point;
    } flags_t;

    // atan(2^-i) in units of 2^-24 degree.
    function automatic logic signed [CorW-1:0] atan_step(input int i);
        logic signed [CorW-1:0] r;
        case (i)
            0:  r = 34'sd754974720;
            1:  r = 34'sd445687602;
            2:  r = 34'sd235489088;
            3:  r = 34'sd119537938;
            4:  r = 34'sd60000934;
            5:  r = 34'sd30029717;
            6:  r = 34'sd15018523;
            7:  r = 34'sd7509720;
            8:  r = 34'sd3754917;
            9:  r = 34'sd1877466;
            10: r = 34'sd938734;
            11: r = 34'sd469367;
            12: r = 34'sd234684;
            13: r = 34'sd117342;
            14: r = 34'sd58671;
            15: r = 34'sd29335;
            16: r = 34'sd14668;
            17: r = 34'sd7334;
            18: r = 34'sd3667;
            19: r = 34'sd1833;
            20: r = 34'sd917;
            21: r = 34'sd458;
            22: r = 34'sd229;
            23: r = 34'sd115;
            24: r = 34'sd57;
            25: r = 34'sd29;
            26: r = 34'sd14;
            27: r = 34'sd7;
            28: r = 34'sd4;
            29: r = 34'sd2;
            30: r = 34'sd1;
            default: r = 34'sd0;
        endcase
        return r;
    endfunction

endpackage

// ----- sv/arc_point_generator_unit.sv -----
// Arc point generator top level: angle interpolation, divider, CORDIC, output scaling.
// Depends on arcpg_pkg.

// Each request carries a point index and returns one point of the configured
// circular arc. The block is fully pipelined and accepts one request per clock
// while the result side does not stall; it holds 27 divider stages plus
// CORDIC_STAGES rotation stages plus 9 more register stages. The pipeline
// moves as a whole, so a stall on the result side holds every stage and
// pushes back on the request side in the same cycle. Configuration writes are
// always taken and must only be made while no request is in flight.
module arc_point_generator_unit
    import arcpg_pkg::*;
#(
    parameter int MAX_POINTS    = 4096,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [2:0]                       cfg_index,
    input  logic [31:0]                      cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [$clog2(MAX_POINTS)-1:0]    point_index,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [31:0]               point_x,
    output logic signed [31:0]               point_y,
    output logic                             index_valid,
    output logic                             is_last_point
);

    localparam int IdxW = $clog2(MAX_POINTS);
    localparam int CntW = $clog2(MAX_POINTS + 1);
    localparam int NumW = 27 + IdxW;
    localparam int MagW = 26 + IdxW;
    localparam int NS   = CORDIC_STAGES;

    // ---------------- configuration registers ----------------
    logic signed [31:0] center_x_reg, center_y_reg;
    logic [30:0]        radius_reg;
    logic signed [25:0] start_reg, end_reg;
    logic [CntW-1:0]    count_reg;
    logic [CntW-1:0]    count_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        count_next = cfg_data[CntW-1:0];
        if (count_next < CntW'(MinPoints))
            count_next = CntW'(MinPoints);
        if (count_next > CntW'(MAX_POINTS))
            count_next = CntW'(MAX_POINTS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            radius_reg   <= 31'd65536;
            start_reg    <= '0;
            end_reg      <= 26'sd5898240;
            count_reg    <= CntW'(50);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_CENTER_X:    center_x_reg <= cfg_data;
                REG_CENTER_Y:    center_y_reg <= cfg_data;
                REG_RADIUS:      radius_reg   <= cfg_data[30:0];
                REG_START_ANGLE: start_reg    <= cfg_data[25:0];
                REG_END_ANGLE:   end_reg      <= cfg_data[25:0];
                REG_POINT_COUNT: count_reg    <= count_next;
                default: ;
            endcase
        end
    end

    // The whole pipeline advances together whenever the result register is free.
    logic adv;
    assign adv      = !out_valid || !out_stall;
    assign in_stall = !adv;

    logic [IdxW-1:0] last;
    assign last = count_reg[IdxW-1:0] - IdxW'(1);

    // ---------------- stage 1: clamp index, multiply ----------------
    logic               v1_reg;
    flags_t             f1_reg;
    logic signed [NumW-1:0] num1_reg;
    flags_t             f1_next;
    logic [IdxW-1:0]    idx_c;
    logic signed [26:0] diff;
    logic signed [NumW:0] prod1;

    always_comb
    begin
        f1_next.index_valid = {1'b0, point_index} < CntW'(count_reg);
        idx_c = f1_next.index_valid ? point_index : last;
        f1_next.is_last_point = (idx_c == last);
        diff  = 27'(end_reg) - 27'(start_reg);
        prod1 = diff * $signed({1'b0, idx_c});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (adv)
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f1_reg   <= f1_next;
            num1_reg <= prod1[NumW-1:0];
        end
    end

    // ---------------- stage 2 and divider: round(|num| / last) ----------------
    logic               dv_reg  [0:QuoW];
    flags_t             df_reg  [0:QuoW];
    logic               dn_reg  [0:QuoW];
    logic [IdxW-1:0]    rem_reg [0:QuoW];
    logic [QuoW-1:0]    lo_reg  [0:QuoW];
    logic [QuoW-1:0]    q_reg   [0:QuoW];
    logic [MagW-1:0]    mag_next;

    always_comb
    begin
        mag_next = (num1_reg < 0) ? MagW'(-num1_reg) : MagW'(num1_reg);
        mag_next = mag_next + MagW'(last >> 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_reg[0] <= 1'b0;
        else if (adv)
            dv_reg[0] <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            df_reg[0]  <= f1_reg;
            dn_reg[0]  <= num1_reg < 0;
            rem_reg[0] <= IdxW'(mag_next[MagW-1:QuoW]);
            lo_reg[0]  <= mag_next[QuoW-1:0];
            q_reg[0]   <= '0;
        end
    end

    for (genvar d = 0; d < QuoW; d++)
    begin : g_div
        logic [IdxW:0] r2;
        logic          ge;
        logic [IdxW:0] diffr;
        assign r2    = {rem_reg[d], lo_reg[d][QuoW-1-d]};
        assign ge    = r2 >= {1'b0, last};
        assign diffr = r2 - {1'b0, last};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_reg[d+1] <= 1'b0;
            else if (adv)
                dv_reg[d+1] <= dv_reg[d];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                df_reg[d+1]  <= df_reg[d];
                dn_reg[d+1]  <= dn_reg[d];
                rem_reg[d+1] <= ge ? diffr[IdxW-1:0] : r2[IdxW-1:0];
                lo_reg[d+1]  <= lo_reg[d];
                q_reg[d+1]   <= {q_reg[d][QuoW-2:0], ge};
            end
        end
    end

    // ---------------- angle reduction to [0, 360) ----------------
    // An offset of eight turns makes the angle positive, then binary subtraction.
    logic             v3_reg, v4_reg, v5_reg;
    flags_t           f3_reg, f4_reg, f5_reg;
    logic [WrapW-1:0] a3_reg, a4_reg, a5_reg;
    logic signed [AngW-1:0] ang;
    logic signed [WrapW:0]  a3_next;
    logic [WrapW-1:0] a4_next, a5_next;

    always_comb
    begin
        ang = AngW'(start_reg) + (dn_reg[QuoW] ? -$signed({1'b0, q_reg[QuoW]})
                                               :  $signed({1'b0, q_reg[QuoW]}));
        a3_next = (WrapW+1)'(ang) + (WrapW+1)'(8 * FullTurn);
        a4_next = a3_reg;
        if (a4_next >= WrapW'(8 * FullTurn))
            a4_next = a4_next - WrapW'(8 * FullTurn);
        if (a4_next >= WrapW'(4 * FullTurn))
            a4_next = a4_next - WrapW'(4 * FullTurn);
        a5_next = a4_reg;
        if (a5_next >= WrapW'(2 * FullTurn))
            a5_next = a5_next - WrapW'(2 * FullTurn);
        if (a5_next >= WrapW'(FullTurn))
            a5_next = a5_next - WrapW'(FullTurn);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (adv)
        begin
            v3_reg <= dv_reg[QuoW];
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f3_reg <= df_reg[QuoW];
            a3_reg <= a3_next[WrapW-1:0];
            f4_reg <= f3_reg;
            a4_reg <= a4_next;
            f5_reg <= f4_reg;
            a5_reg <= a5_next;
        end
    end

    // ---------------- fold into [-90, 90] and CORDIC ----------------
    logic                   cv_reg [0:NS];
    flags_t                 cf_reg [0:NS];
    logic                   cn_reg [0:NS];
    logic signed [CorW-1:0] x_reg  [0:NS];
    logic signed [CorW-1:0] y_reg  [0:NS];
    logic signed [CorW-1:0] z_reg  [0:NS];
    logic signed [26:0]     fold;
    logic                   fold_neg;

    always_comb
    begin
        fold     = $signed({2'b00, a5_reg[24:0]});
        fold_neg = 1'b0;
        if (a5_reg > WrapW'(QuarterTurn) && a5_reg < WrapW'(ThreeQuarter))
        begin
            fold     = fold - 27'sd11796480;
            fold_neg = 1'b1;
        end
        else if (a5_reg >= WrapW'(ThreeQuarter))
            fold = fold - 27'sd23592960;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cv_reg[0] <= 1'b0;
        else if (adv)
            cv_reg[0] <= v5_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cf_reg[0] <= f5_reg;
            cn_reg[0] <= fold_neg;
            x_reg[0]  <= CorW'(CordicGain);
            y_reg[0]  <= '0;
            z_reg[0]  <= CorW'(fold) <<< 8;
        end
    end

    for (genvar c = 0; c < NS; c++)
    begin : g_cordic
        logic signed [CorW-1:0] xs, ys;
        logic                   pos;
        assign xs  = x_reg[c] >>> c;
        assign ys  = y_reg[c] >>> c;
        assign pos = z_reg[c] >= 0;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                cv_reg[c+1] <= 1'b0;
            else if (adv)
                cv_reg[c+1] <= cv_reg[c];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                cf_reg[c+1] <= cf_reg[c];
                cn_reg[c+1] <= cn_reg[c];
                x_reg[c+1]  <= pos ? x_reg[c] - ys : x_reg[c] + ys;
                y_reg[c+1]  <= pos ? y_reg[c] + xs : y_reg[c] - xs;
                z_reg[c+1]  <= pos ? z_reg[c] - atan_step(c) : z_reg[c] + atan_step(c);
            end
        end
    end

    // ---------------- sign fix, scale by radius, offset, saturate ----------------
    logic               v7_reg, v8_reg, v9_reg;
    flags_t             f7_reg, f8_reg, f9_reg;
    logic signed [31:0] c7_reg, s7_reg;
    logic signed [63:0] px8_reg, py8_reg;
    logic signed [31:0] x9_reg, y9_reg;
    logic signed [CorW-1:0] c7_next, s7_next;
    logic signed [63:0] px_round, py_round;
    logic signed [34:0] sx, sy;
    logic signed [31:0] x9_next, y9_next;

    always_comb
    begin
        c7_next  = cn_reg[NS] ? -x_reg[NS] : x_reg[NS];
        s7_next  = cn_reg[NS] ? -y_reg[NS] : y_reg[NS];
        px_round = (px8_reg + 64'sd536870912) >>> 30;
        py_round = (py8_reg + 64'sd536870912) >>> 30;
        sx = 35'(center_x_reg) + 35'($signed(px_round[33:0]));
        sy = 35'(center_y_reg) + 35'($signed(py_round[33:0]));
        if (sx > 35'sd2147483647)
            x9_next = 32'sh7FFFFFFF;
        else if (sx < -35'sd2147483648)
            x9_next = 32'sh80000000;
        else
            x9_next = sx[31:0];
        if (sy > 35'sd2147483647)
            y9_next = 32'sh7FFFFFFF;
        else if (sy < -35'sd2147483648)
            y9_next = 32'sh80000000;
        else
            y9_next = sy[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
            v9_reg <= 1'b0;
        end
        else if (adv)
        begin
            v7_reg <= cv_reg[NS];
            v8_reg <= v7_reg;
            v9_reg <= v8_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f7_reg  <= cf_reg[NS];
            c7_reg  <= c7_next[31:0];
            s7_reg  <= s7_next[31:0];
            f8_reg  <= f7_reg;
            px8_reg <= 64'($signed({1'b0, radius_reg}) * c7_reg);
            py8_reg <= 64'($signed({1'b0, radius_reg}) * s7_reg);
            f9_reg  <= f8_reg;
            x9_reg  <= x9_next;
            y9_reg  <= y9_next;
        end
    end

    assign out_valid     = v9_reg;
    assign point_x       = x9_reg;
    assign point_y       = y9_reg;
    assign index_valid   = f9_reg.index_valid;
    assign is_last_point = f9_reg.is_last_point;

endmodule
